@@ design/vdmc_pkg.sv @@
// Shared types and constants for the vehicle drive mode controller.
package vdmc_pkg;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DISCOVERY_W = 16;
    localparam int DEBOUNCE_W = 8;
    localparam int INFO_W = 6;

    typedef enum logic [2:0] {
        MODE_BOOT   = 3'd0,
        MODE_CONFIG = 3'd1,
        MODE_READY  = 3'd2,
        MODE_ON     = 3'd3,
        MODE_FAULT  = 3'd4
    } mode_t;

    localparam logic [1:0] WIFI_NONE    = 2'd0;
    localparam logic [1:0] WIFI_ENABLE  = 2'd1;
    localparam logic [1:0] WIFI_DISABLE = 2'd2;

    localparam logic [1:0] LOG_NONE  = 2'd0;
    localparam logic [1:0] LOG_START = 2'd1;
    localparam logic [1:0] LOG_STOP  = 2'd2;

    localparam logic [1:0] ERR_NONE           = 2'd0;
    localparam logic [1:0] ERR_SAFETY_MISSING = 2'd1;
    localparam logic [1:0] ERR_INFO_MISSING   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISCOVERY_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIFI_ON_RUN     = 2'd2;

    localparam logic [DISCOVERY_W-1:0] DISCOVERY_RESET = 16'd200;
    localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_RESET  = 8'd5;

    localparam logic [INFO_W-1:0] INFO_ALL_PRESENT = 6'h3F;

    typedef struct packed {
        logic [DISCOVERY_W-1:0] discovery_ticks;
        logic [DEBOUNCE_W-1:0]  debounce_ticks;
        logic                   wifi_on_while_running;
    } cfg_t;

    typedef struct packed {
        logic              button_raw;
        logic              ready_request;
        logic              stop_request;
        logic              error_latched;
        logic              logger_recording;
        logic              safety_node_failed;
        logic              safety_nodes_healthy;
        logic              nodes_configured;
        logic [INFO_W-1:0] informative_present;
    } in_item_t;

    typedef struct packed {
        mode_t      vehicle_mode;
        logic       mode_changed;
        logic [1:0] wifi_command;
        logic [1:0] logger_command;
        logic [1:0] error_report;
    } result_t;

endpackage

@@ design/vdmc_cfg_regs.sv @@
// Configuration register file of the drive mode controller.
module vdmc_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [vdmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [vdmc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output vdmc_pkg::cfg_t                     cfg
);
    import vdmc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.discovery_ticks       <= DISCOVERY_RESET;
            cfg_reg.debounce_ticks        <= DEBOUNCE_RESET;
            cfg_reg.wifi_on_while_running <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DISCOVERY_TICKS: begin
                    cfg_reg.discovery_ticks <= cfg_data[DISCOVERY_W-1:0];
                end
                CFG_DEBOUNCE_TICKS: begin
                    cfg_reg.debounce_ticks <= cfg_data[DEBOUNCE_W-1:0];
                end
                CFG_WIFI_ON_RUN: begin
                    cfg_reg.wifi_on_while_running <= cfg_data[0];
                end
                default: begin
                    // drop writes outside the register list
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/vdmc_mode_core.sv @@
// Mode state machine, request latches, tick counter and button debounce.
module vdmc_mode_core #(
    parameter int TICK_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  vdmc_pkg::in_item_t   item,
    input  vdmc_pkg::cfg_t       cfg,
    output vdmc_pkg::result_t    res
);
    import vdmc_pkg::*;

    mode_t                mode_reg, mode_next;
    logic                 ready_pending_reg, ready_pending_next;
    logic                 shutdown_pending_reg, shutdown_pending_next;
    logic [TICK_BITS-1:0] tick_now_reg, tick_now_next;
    logic                 button_last_raw_reg, button_last_raw_next;
    logic                 button_stable_reg, button_stable_next;
    logic [TICK_BITS-1:0] button_change_tick_reg, button_change_tick_next;

    logic [TICK_BITS-1:0] button_age;
    logic                 debounce_done;
    logic                 window_done;
    logic                 changed;
    logic [1:0]           report;

    assign button_age    = tick_now_reg - button_change_tick_reg;
    assign debounce_done = !(button_age < TICK_BITS'(cfg.debounce_ticks));
    assign window_done   = !(tick_now_reg < TICK_BITS'(cfg.discovery_ticks));
    assign tick_now_next = tick_now_reg + TICK_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg               <= MODE_BOOT;
            ready_pending_reg      <= 1'b0;
            shutdown_pending_reg   <= 1'b0;
            tick_now_reg           <= '0;
            button_last_raw_reg    <= 1'b0;
            button_stable_reg      <= 1'b0;
            button_change_tick_reg <= '0;
        end else if (step) begin
            mode_reg               <= mode_next;
            ready_pending_reg      <= ready_pending_next;
            shutdown_pending_reg   <= shutdown_pending_next;
            tick_now_reg           <= tick_now_next;
            button_last_raw_reg    <= button_last_raw_next;
            button_stable_reg      <= button_stable_next;
            button_change_tick_reg <= button_change_tick_next;
        end
    end

    always_comb begin
        mode_next               = mode_reg;
        report                  = ERR_NONE;
        ready_pending_next      = ready_pending_reg | item.ready_request;
        shutdown_pending_next   = shutdown_pending_reg | item.stop_request;
        button_last_raw_next    = button_last_raw_reg;
        button_stable_next      = button_stable_reg;
        button_change_tick_next = button_change_tick_reg;

        if (item.error_latched && mode_reg != MODE_FAULT) begin
            mode_next = MODE_FAULT;
        end else begin
            case (mode_reg)
                MODE_BOOT: begin
                    if (item.safety_node_failed) begin
                        report    = ERR_SAFETY_MISSING;
                        mode_next = MODE_FAULT;
                    end else if (window_done) begin
                        if (item.safety_nodes_healthy) begin
                            if (item.informative_present != INFO_ALL_PRESENT) begin
                                report = ERR_INFO_MISSING;
                            end
                            mode_next = MODE_CONFIG;
                        end else begin
                            report    = ERR_SAFETY_MISSING;
                            mode_next = MODE_FAULT;
                        end
                    end
                end
                MODE_CONFIG: begin
                    if (item.nodes_configured) begin
                        mode_next = MODE_READY;
                    end
                end
                MODE_READY: begin
                    if (ready_pending_next) begin
                        ready_pending_next = 1'b0;
                        mode_next          = MODE_ON;
                    end else if (item.button_raw != button_last_raw_reg) begin
                        // restart the stability window on any raw change
                        button_last_raw_next    = item.button_raw;
                        button_change_tick_next = tick_now_reg;
                    end else if (debounce_done) begin
                        button_stable_next = item.button_raw;
                        if (item.button_raw && !button_stable_reg) begin
                            mode_next = MODE_ON;
                        end
                    end
                end
                MODE_ON: begin
                    if (!item.logger_recording || shutdown_pending_next) begin
                        shutdown_pending_next = 1'b0;
                        mode_next             = MODE_READY;
                    end
                end
                default: begin
                end
            endcase
        end

        changed = (mode_next != mode_reg);

        res.vehicle_mode   = mode_next;
        res.mode_changed   = changed;
        res.error_report   = report;
        res.wifi_command   = WIFI_NONE;
        res.logger_command = LOG_NONE;
        if (changed) begin
            res.wifi_command = (mode_next == MODE_ON && !cfg.wifi_on_while_running)
                               ? WIFI_DISABLE : WIFI_ENABLE;
            case (mode_next)
                MODE_ON:    res.logger_command = LOG_START;
                MODE_READY: res.logger_command = LOG_STOP;
                MODE_FAULT: res.logger_command = LOG_STOP;
                default:    res.logger_command = LOG_NONE;
            endcase
        end
    end

endmodule

@@ design/vehicle_drive_mode_controller_core.sv @@
// Top level of the vehicle drive mode controller: stream ports and pipeline registers.
//
// One input word per control tick arrives on the s_ stream; each word gives
// exactly one result word on the m_ stream, in order. The word is held in an
// input register, the mode logic evaluates it combinationally and the result
// lands in an output register that drives m_tvalid and m_tdata. One word is
// accepted every cycle while the receiver keeps up.
// When m_tready is low the result register holds its word and the input
// register fills; s_tready then falls until the result is taken.
// The cfg_ channel writes one register per handshake (index 0 discovery
// ticks, 1 debounce ticks, 2 wifi-on-while-running); cfg_ready is always
// high and writes take effect the next cycle. Write only while no word is
// in flight.
// Reset (aresetn low at a clock edge) empties both registers, puts the mode
// in boot, clears the request latches, the tick counter and the debounce
// state, and restores the register defaults.
module vehicle_drive_mode_controller_core #(
    parameter int TICK_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] button_raw, [1] ready_request, [2] stop_request,
    // [3] error_latched, [4] logger_recording, [5] safety_node_failed,
    // [6] safety_nodes_healthy, [7] nodes_configured,
    // [13:8] informative_present, [15:14] zero
    input  logic [vdmc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] vehicle_mode, [3] mode_changed, [5:4] wifi_command,
    // [7:6] logger_command, [9:8] error_report, [15:10] zero
    output logic [vdmc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vdmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vdmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import vdmc_pkg::*;

    logic     in_valid_reg;
    in_item_t in_item_reg;
    in_item_t s_item;
    logic     out_valid_reg;
    result_t  out_res_reg;
    result_t  res;
    cfg_t     cfg;
    logic     advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        s_item.button_raw           = s_tdata[0];
        s_item.ready_request        = s_tdata[1];
        s_item.stop_request         = s_tdata[2];
        s_item.error_latched        = s_tdata[3];
        s_item.logger_recording     = s_tdata[4];
        s_item.safety_node_failed   = s_tdata[5];
        s_item.safety_nodes_healthy = s_tdata[6];
        s_item.nodes_configured     = s_tdata[7];
        s_item.informative_present  = s_tdata[8 +: INFO_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: hold unless a new word moves in
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    vdmc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vdmc_mode_core #(
        .TICK_BITS (TICK_BITS)
    ) u_mode_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.error_report, out_res_reg.logger_command,
                       out_res_reg.wifi_command, out_res_reg.mode_changed,
                       out_res_reg.vehicle_mode};

endmodule

@@ design/vdmc_checker.sv @@
// Port-level checks for the drive mode controller, bound to the top level.
module vdmc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [vdmc_pkg::M_TDATA_W-1:0] m_tdata
);
    import vdmc_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // without a transition every command and report is quiet
    a_quiet_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> m_tdata[9:4] == 6'd0)
        else $error("command issued without a mode transition");

    // every transition carries a wifi command
    a_wifi_on_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[5:4] != WIFI_NONE)
        else $error("transition without wifi command");

    // an error report only comes with a move into config or fault
    a_report_move: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:8] != ERR_NONE |->
            m_tdata[3] && (m_tdata[2:0] == MODE_CONFIG || m_tdata[2:0] == MODE_FAULT))
        else $error("error report on an unexpected transition");

endmodule

bind vehicle_drive_mode_controller_core vdmc_checker u_vdmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
